// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the heading controller RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/phc_pkg.sv =====
// Shared widths, register indexes and stage word types of the heading controller.
// Depends on nothing; imported by every module of the block.
package phc_pkg;

  localparam int ERR_W    = 17;
  localparam int ACC_W    = 25;
  localparam int DIFF_W   = 18;
  localparam int GAIN_W   = 16;
  localparam int LIM_W    = 15;
  localparam int DRIVE_W  = 16;
  localparam int PP_W     = 34;
  localparam int PI_W     = 42;
  localparam int PD_W     = 35;
  localparam int SUM_W    = 43;
  localparam int FRAC_SH  = 16;
  localparam int SH_W     = SUM_W - FRAC_SH;
  localparam int CFG_IDX_W = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_PROP_RST   = 16'd512;
  localparam logic [GAIN_W-1:0] GAIN_INTEG_RST  = 16'd0;
  localparam logic [GAIN_W-1:0] GAIN_DERIV_RST  = 16'd1280;
  localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = 15'd300;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd1000;

  // Error, updated integral and error difference of one sample.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [ACC_W-1:0]  integ;
    logic signed [DIFF_W-1:0] diff;
  } terms_t;

  // The three gain products of one sample.
  typedef struct packed {
    logic signed [PP_W-1:0] prod_p;
    logic signed [PI_W-1:0] prod_i;
    logic signed [PD_W-1:0] prod_d;
  } prods_t;

endpackage

// ===== hw/rtl/phc_integ.sv =====
// Integral and previous-error state with the first pipeline register.
// Depends on phc_pkg.
module phc_integ
  import phc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic signed [ERR_W-1:0] err,
  input  logic [LIM_W-1:0]        integ_limit,
  output terms_t                  terms
);

  localparam int WIDE_W = ACC_W + 1;

  logic signed [ACC_W-1:0]  integ_r, integ_nxt;
  logic signed [ERR_W-1:0]  prev_r;
  terms_t                   terms_r, terms_nxt;
  logic signed [WIDE_W-1:0] raw_sum;
  logic signed [WIDE_W-1:0] lim_pos;
  logic signed [WIDE_W-1:0] lim_neg;

  always_comb begin
    raw_sum = {integ_r[ACC_W-1], integ_r} + {{(WIDE_W-ERR_W){err[ERR_W-1]}}, err};
    lim_pos = $signed({3'b000, integ_limit, 8'h00});
    lim_neg = -lim_pos;
    if (raw_sum > lim_pos) begin
      integ_nxt = lim_pos[ACC_W-1:0];
    end else if (raw_sum < lim_neg) begin
      integ_nxt = lim_neg[ACC_W-1:0];
    end else begin
      integ_nxt = raw_sum[ACC_W-1:0];
    end
    terms_nxt.err   = err;
    terms_nxt.integ = integ_nxt;
    terms_nxt.diff  = {err[ERR_W-1], err} - {prev_r[ERR_W-1], prev_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      prev_r  <= '0;
    end else if (accept) begin
      integ_r <= integ_nxt;
      prev_r  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      terms_r <= terms_nxt;
    end
  end

  assign terms = terms_r;

endmodule

// ===== hw/rtl/phc_mult.sv =====
// Three parallel gain multipliers with their product register.
// Depends on phc_pkg.
module phc_mult
  import phc_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  terms_t            terms,
  input  logic [GAIN_W-1:0] gain_prop,
  input  logic [GAIN_W-1:0] gain_integ,
  input  logic [GAIN_W-1:0] gain_deriv,
  output prods_t            prods
);

  prods_t prods_r, prods_nxt;
  logic signed [GAIN_W:0] gp_s, gi_s, gd_s;

  always_comb begin
    // Gains are unsigned, so a zero sign bit makes them safe signed operands.
    gp_s = $signed({1'b0, gain_prop});
    gi_s = $signed({1'b0, gain_integ});
    gd_s = $signed({1'b0, gain_deriv});
    prods_nxt.prod_p = gp_s * terms.err;
    prods_nxt.prod_i = gi_s * terms.integ;
    prods_nxt.prod_d = gd_s * terms.diff;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prods_r <= prods_nxt;
    end
  end

  assign prods = prods_r;

endmodule

// ===== hw/rtl/phc_out.sv =====
// Sum, floor shift, symmetric clamp and negation into the result register.
// Depends on phc_pkg.
module phc_out
  import phc_pkg::*;
(
  input  logic                      clk,
  input  logic                      load,
  input  prods_t                    prods,
  input  logic [LIM_W-1:0]          drive_limit,
  output logic signed [DRIVE_W-1:0] drive
);

  logic signed [SUM_W-1:0]   sum;
  logic signed [SH_W-1:0]    shifted;
  logic signed [SH_W-1:0]    lim_pos;
  logic signed [SH_W-1:0]    lim_neg;
  logic signed [SH_W-1:0]    clamped;
  logic signed [SH_W-1:0]    negated;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;

  always_comb begin
    sum = {{(SUM_W-PP_W){prods.prod_p[PP_W-1]}}, prods.prod_p}
        + {{(SUM_W-PI_W){prods.prod_i[PI_W-1]}}, prods.prod_i}
        + {{(SUM_W-PD_W){prods.prod_d[PD_W-1]}}, prods.prod_d};
    // Dropping the low bits of a two's complement word rounds toward minus infinity.
    shifted = sum[SUM_W-1:FRAC_SH];
    lim_pos = $signed({{(SH_W-LIM_W){1'b0}}, drive_limit});
    lim_neg = -lim_pos;
    if (shifted > lim_pos) begin
      clamped = lim_pos;
    end else if (shifted < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = shifted;
    end
    negated   = -clamped;
    drive_nxt = negated[DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

endmodule

// ===== hw/rtl/pid_heading_controller_unit.sv =====
// Positional PID heading controller with integral clamp: top level.
// Depends on phc_pkg, phc_integ, phc_mult, phc_out and assert_macros.svh.
//
// Usage: one heading error word (signed degrees, 8 fraction bits) goes in on the
// in_ stream and one drive word (whole drive units, signed) comes out on the out_
// stream for every word accepted, in the same order.
// The integral is updated and clamped in the cycle a word is accepted, the three
// gain products are formed in the next stage, and the sum, floor shift by 16,
// output clamp and negation fill the result register in the third.
// Throughput is one word per cycle while the receiver does not stall; the rate is
// set by the loop that adds the new error into the clamped integral register.
// Each stage has its own valid bit, so when the receiver stalls the pipeline
// keeps filling its empty stages and in_tready only falls once all three hold
// a word. A stalled result stays stable on out_tdata until taken.
// Gains and limits are written through the cfg_ port; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// Synchronous reset loads the register defaults (gains 2.0, 0.0 and 5.0,
// integral limit 300, drive limit 1000), clears the integral and the previous
// error, and empties the pipeline.
module pid_heading_controller_unit
  import phc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write port.
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [GAIN_W-1:0]        cfg_wdata,
  // Input stream.
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_TDATA_W-1:0]    in_tdata,   // [16:0] heading_error, [23:17] zero
  // Result stream.
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_TDATA_W-1:0]   out_tdata   // [15:0] drive_value
);

`include "assert_macros.svh"

  logic [GAIN_W-1:0] gain_prop_r;
  logic [GAIN_W-1:0] gain_integ_r;
  logic [GAIN_W-1:0] gain_deriv_r;
  logic [LIM_W-1:0]  integ_limit_r;
  logic [LIM_W-1:0]  drive_limit_r;

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;
  logic in_accept;

  logic signed [ERR_W-1:0]   heading_error;
  terms_t                    terms;
  prods_t                    prods;
  logic signed [DRIVE_W-1:0] drive_value;

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r   <= GAIN_PROP_RST;
      gain_integ_r  <= GAIN_INTEG_RST;
      gain_deriv_r  <= GAIN_DERIV_RST;
      integ_limit_r <= INTEG_LIMIT_RST;
      drive_limit_r <= DRIVE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_PROP:   gain_prop_r   <= cfg_wdata;
        REG_GAIN_INTEG:  gain_integ_r  <= cfg_wdata;
        REG_GAIN_DERIV:  gain_deriv_r  <= cfg_wdata;
        REG_INTEG_LIMIT: integ_limit_r <= cfg_wdata[LIM_W-1:0];
        REG_DRIVE_LIMIT: drive_limit_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage moves on when the one after it is empty or moving on itself.
  assign adv3      = !v3_r || out_tready;
  assign adv2      = !v2_r || adv3;
  assign adv1      = !v1_r || adv2;
  assign in_tready = adv1;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_tvalid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  assign heading_error = $signed(in_tdata[ERR_W-1:0]);

  phc_integ u_integ (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .err         (heading_error),
    .integ_limit (integ_limit_r),
    .terms       (terms)
  );

  phc_mult u_mult (
    .clk        (clk),
    .load       (v1_r && adv2),
    .terms      (terms),
    .gain_prop  (gain_prop_r),
    .gain_integ (gain_integ_r),
    .gain_deriv (gain_deriv_r),
    .prods      (prods)
  );

  phc_out u_out (
    .clk         (clk),
    .load        (v2_r && adv3),
    .prods       (prods),
    .drive_limit (drive_limit_r),
    .drive       (drive_value)
  );

  assign out_tvalid = v3_r;
  assign out_tdata  = drive_value;

  // A shown result never exceeds the drive limit in magnitude.
  `ASSERT_IMPLY(a_drive_in_limit, clk, rst_n, out_tvalid,
    ($signed(out_tdata) <= $signed({1'b0, drive_limit_r})) &&
    ($signed(out_tdata) >= -$signed({1'b0, drive_limit_r})))

  // With a zero integral limit the integral carried down the pipe is zero.
  `ASSERT_NEXT(a_zero_integ_limit, clk, rst_n,
    in_accept && (integ_limit_r == '0), terms.integ == '0)

  // The first stage holds exactly the error that was accepted.
  `ASSERT_NEXT(a_err_captured, clk, rst_n, in_accept,
    terms.err == $past(heading_error))

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PID heading controller top level.
// Depends on phc_pkg and pid_heading_controller_unit, which brings in its own submodules.
`timescale 1ns / 1ps

module testbench;
  import phc_pkg::*;

  // Cycles allowed for the three-stage pipeline to empty, with a little margin.
  localparam int PIPE_LAT = 6;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [GAIN_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [16:0] heading_error, [23:17] zero
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] drive_value

  // Our own copy of the register file and the controller state.
  logic [GAIN_W-1:0]        kp_model;
  logic [GAIN_W-1:0]        ki_model;
  logic [GAIN_W-1:0]        kd_model;
  logic [LIM_W-1:0]         ilim_model;
  logic [LIM_W-1:0]         dlim_model;
  logic signed [ACC_W-1:0]  integ_model;
  logic signed [ERR_W-1:0]  prev_err_model;

  // Drive words still owed by the block, oldest first.
  logic [DRIVE_W-1:0] drive_expected[$];
  logic [DRIVE_W-1:0] drive_want;
  int                 mismatch_count;
  int                 words_out;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int src_idle_pct;
  int snk_stall_pct;

  // State of the random error generator: the current run of similar errors.
  int run_left;
  int run_base;

  pid_heading_controller_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #(5_000_000);
    $display("FAIL pid_heading_controller_unit");
    $finish;
  end

  // Receiver: stalls at random, changing tready only on the falling edge.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Predicts one drive word and advances the model state. The integral is
  // updated and clamped first, then the three gain terms are summed; every
  // intermediate is held in 64 bits so that no term can wrap. The arithmetic
  // shift of a signed value rounds towards minus infinity, as required.
  function automatic logic [DRIVE_W-1:0] predict_drive(input logic [ERR_W-1:0] raw);
    longint err;
    longint lim;
    longint acc;
    longint sum;
    longint drv;
    err = $signed(raw);
    lim = longint'(ilim_model) * 256;
    acc = integ_model + err;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    sum = longint'(kp_model) * err
        + longint'(ki_model) * acc
        + longint'(kd_model) * (err - prev_err_model);
    integ_model    = acc[ACC_W-1:0];
    prev_err_model = raw;
    drv = sum >>> FRAC_SH;
    if (drv > longint'(dlim_model)) drv = dlim_model;
    if (drv < -longint'(dlim_model)) drv = -longint'(dlim_model);
    drv = -drv;
    return drv[DRIVE_W-1:0];
  endfunction

  // Compares every accepted result word with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (drive_expected.size() == 0) begin
        report_mismatch($sformatf("drive word %0d: got %0d with no word expected",
                                  words_out, $signed(out_tdata[DRIVE_W-1:0])));
      end else begin
        drive_want = drive_expected.pop_front();
        if (out_tdata[DRIVE_W-1:0] !== drive_want)
          report_mismatch($sformatf("drive word %0d: drive_value got %0d want %0d",
                                    words_out, $signed(out_tdata[DRIVE_W-1:0]),
                                    $signed(drive_want)));
      end
      words_out++;
    end
  end

  // Sends one heading error word, idling beforehand at the current rate, and
  // records the prediction once the word has been taken.
  task automatic send_error(input logic [ERR_W-1:0] err);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_TDATA_W - ERR_W){1'b0}}, err};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    drive_expected.push_back(predict_drive(err));
  endtask

  // Drops valid and waits until every owed word has arrived and the pipeline
  // has had time to empty. Returns just after a falling edge.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (drive_expected.size() != 0) @(negedge clk);
    repeat (PIPE_LAT) @(negedge clk);
  endtask

  // Writes one register while the block is idle and mirrors it in the model.
  // Bits above a register's width are dropped; indexes past the list do nothing.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      REG_GAIN_PROP:   kp_model   = value;
      REG_GAIN_INTEG:  ki_model   = value;
      REG_GAIN_DERIV:  kd_model   = value;
      REG_INTEG_LIMIT: ilim_model = value[LIM_W-1:0];
      REG_DRIVE_LIMIT: dlim_model = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic cfg_write_all(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                               input logic [GAIN_W-1:0] kd, input logic [GAIN_W-1:0] ilim,
                               input logic [GAIN_W-1:0] dlim);
    cfg_write(REG_GAIN_PROP, kp);
    cfg_write(REG_GAIN_INTEG, ki);
    cfg_write(REG_GAIN_DERIV, kd);
    cfg_write(REG_INTEG_LIMIT, ilim);
    cfg_write(REG_DRIVE_LIMIT, dlim);
  endtask

  // Random heading errors. Most come in runs of similar sign and size, which is
  // what drives the integral into its clamp; the rest are single words drawn
  // from any 17-bit pattern, the range ends or the stated range.
  function automatic logic [ERR_W-1:0] next_heading_error();
    int v;
    if (run_left == 0 && $urandom_range(99) < 65) begin
      run_left = $urandom_range(4, 24);
      run_base = int'($urandom_range(0, 92160)) - 46080;
    end
    if (run_left != 0) begin
      run_left--;
      v = run_base + int'($urandom_range(0, 1024)) - 512;
    end else begin
      case ($urandom_range(2))
        0: v = int'($urandom_range(0, (1 << ERR_W) - 1));
        1: begin
          case ($urandom_range(3))
            0: v = 46080;
            1: v = -46080;
            2: v = 32'h0FFFF;
            default: v = 32'h10000;
          endcase
        end
        default: v = int'($urandom_range(0, 92160)) - 46080;
      endcase
    end
    return ERR_W'(v);
  endfunction

  // Words sent straight after reset must see the default gains and limits.
  task automatic test_reset_defaults();
    send_error(17'sd0);
    send_error(17'sd256);
    send_error(-17'sd256);
    send_error(17'sd46080);
    send_error(-17'sd46080);
  endtask

  // Field extremes, zero limits and the rounding of negative sums.
  task automatic test_extremes();
    cfg_write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF);
    send_error(17'h0FFFF);
    send_error(17'h10000);
    send_error(17'h1FFFF);
    send_error(17'h00001);
    // A zero integral limit must hold the integral at zero.
    cfg_write(REG_INTEG_LIMIT, 16'h0000);
    send_error(17'sd46080);
    send_error(17'sd46080);
    // A zero drive limit forces every drive word to zero.
    cfg_write(REG_DRIVE_LIMIT, 16'h0000);
    send_error(17'sd46080);
    send_error(-17'sd46080);
    // A sum of minus one must floor to minus one, not truncate to zero.
    cfg_write_all(16'd1, 16'd0, 16'd0, 16'd300, 16'h7FFF);
    send_error(-17'sd1);
    send_error(17'sd1);
    send_error(-17'sd65537 + 17'sd1);
  endtask

  // Writes past the register list are ignored and bits above a register's
  // width are dropped.
  task automatic test_register_masking();
    cfg_write_all(16'd300, 16'd200, 16'd100, 16'd1000, 16'd20000);
    for (int idx = int'(REG_DRIVE_LIMIT) + 1; idx < (1 << CFG_IDX_W); idx++)
      cfg_write(CFG_IDX_W'(idx), 16'h0000);
    send_error(17'sd12800);
    send_error(-17'sd3000);
    cfg_write(REG_INTEG_LIMIT, 16'hFFFF);
    cfg_write(REG_DRIVE_LIMIT, 16'hFFFF);
    send_error(17'sd46080);
    send_error(17'sd46080);
  endtask

  // Random words over several register settings, each run through every
  // idling mode so that gaps land on every pipeline stage.
  task automatic test_random_settings();
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
    logic [GAIN_W-1:0] ilim;
    logic [GAIN_W-1:0] dlim;
    for (int s = 0; s < 8; s++) begin
      case (s)
        0: begin
          kp = GAIN_PROP_RST;
          ki = GAIN_INTEG_RST;
          kd = GAIN_DERIV_RST;
          ilim = INTEG_LIMIT_RST;
          dlim = DRIVE_LIMIT_RST;
        end
        1: begin
          kp = 16'hFFFF;
          ki = 16'hFFFF;
          kd = 16'hFFFF;
          ilim = 16'h7FFF;
          dlim = 16'h7FFF;
        end
        2: begin
          kp = '0;
          ki = '0;
          kd = '0;
          ilim = '0;
          dlim = '0;
        end
        default: begin
          // Modest gains keep most sums inside the drive limit.
          kp = ($urandom_range(7) == 0) ? 16'hFFFF : GAIN_W'($urandom_range(0, 1536));
          ki = GAIN_W'($urandom_range(0, 256));
          kd = GAIN_W'($urandom_range(0, 2048));
          ilim = ($urandom_range(3) == 0) ? 16'h7FFF : GAIN_W'($urandom_range(0, 400));
          dlim = ($urandom_range(3) == 0) ? 16'h7FFF : GAIN_W'($urandom_range(0, 3000));
        end
      endcase
      cfg_write_all(kp, ki, kd, ilim, dlim);
      for (int mode = 0; mode < 4; mode++) begin
        case (mode)
          0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
          1: begin src_idle_pct = 70; snk_stall_pct = 0;  end
          2: begin src_idle_pct = 0;  snk_stall_pct = 70; end
          default: begin src_idle_pct = 9; snk_stall_pct = 9; end
        endcase
        for (int n = 0; n < 17; n++) begin
          // Now and then the sender holds off until the block has drained.
          if (n == 8 && mode == 1) wait_idle();
          send_error(next_heading_error());
        end
      end
      src_idle_pct  = 0;
      snk_stall_pct = 0;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    run_left       = 0;
    run_base       = 0;
    mismatch_count = 0;
    words_out      = 0;
    kp_model       = GAIN_PROP_RST;
    ki_model       = GAIN_INTEG_RST;
    kd_model       = GAIN_DERIV_RST;
    ilim_model     = INTEG_LIMIT_RST;
    dlim_model     = DRIVE_LIMIT_RST;
    integ_model    = '0;
    prev_err_model = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_extremes();
    test_register_masking();
    test_random_settings();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS pid_heading_controller_unit");
    end else begin
      $display("FAIL pid_heading_controller_unit");
    end
    $finish;
  end

endmodule

// ===== pid_heading_controller_unit.f =====
+incdir+hw/rtl
hw/rtl/phc_pkg.sv
hw/rtl/phc_integ.sv
hw/rtl/phc_mult.sv
hw/rtl/phc_out.sv
hw/rtl/pid_heading_controller_unit.sv
tb/testbench.sv
